[design/msaa_pkg.sv]
// Shared constants and types for the multisample box resolve block.
`default_nettype none

package msaa_pkg;

    localparam int CH_W        = 8;
    localparam int CHANNELS    = 4;
    localparam int DEPTH_W     = 32;
    localparam int TDATA_W     = CHANNELS * CH_W + DEPTH_W;
    localparam int SC_W        = 5;
    localparam int DIM_REG_W   = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int STEP_W      = $clog2(CH_W);

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [SC_W-1:0]      SAMPLE_COUNT_RESET = 5'd1;
    localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef logic [CH_W-1:0]    chan_t;
    typedef logic [DEPTH_W-1:0] depth_t;

endpackage

`default_nettype wire

[design/msaa_front.sv]
// Front end: config registers, per-pixel accumulation, depth minimum and frame counters.
`default_nettype none

module msaa_front
    import msaa_pkg::*;
#(
    parameter int MAX_SAMPLES   = 16,
    parameter int MAX_DIMENSION = 4096,
    parameter int SUM_W         = 12,
    parameter int N_W           = 5,
    parameter int CNT_W         = 12
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                        sample_take,
    input  wire chan_t [CHANNELS-1:0]        sample_chan,
    input  wire depth_t                      sample_depth,
    output logic                             pix_push,
    output logic [CHANNELS-1:0][SUM_W-1:0]   pix_sum,
    output depth_t                           pix_depth,
    output logic [N_W-1:0]                   pix_n,
    output logic                             pix_last
);

    localparam int DIM_W = CNT_W + 1;

    logic [SC_W-1:0]                 sample_count_reg;
    logic [DIM_REG_W-1:0]            frame_width_reg;
    logic [DIM_REG_W-1:0]            frame_height_reg;
    logic [N_W-1:0]                  idx_reg, idx_next;
    logic [CHANNELS-1:0][SUM_W-1:0]  sum_reg, sum_next;
    depth_t                          nearest_reg, nearest_next;
    logic [CNT_W-1:0]                col_reg, col_next;
    logic [CNT_W-1:0]                row_reg, row_next;

    logic [N_W-1:0]                  n_eff;
    logic [DIM_W-1:0]                w_eff, h_eff;
    logic [CNT_W-1:0]                w_last, h_last;
    logic [N_W:0]                    idx_inc;
    logic                            close;
    logic                            last_col, last_row;
    logic [CHANNELS-1:0][SUM_W-1:0]  acc_sum;
    depth_t                          depth_min;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RESET;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[SC_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_REG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero reads as one, large values saturate
    always_comb
    begin
        if (sample_count_reg == '0)
            n_eff = N_W'(1);
        else if (32'(sample_count_reg) > 32'(MAX_SAMPLES))
            n_eff = N_W'(MAX_SAMPLES);
        else
            n_eff = N_W'(sample_count_reg);

        if (frame_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(frame_width_reg) > 32'(MAX_DIMENSION))
            w_eff = DIM_W'(MAX_DIMENSION);
        else
            w_eff = DIM_W'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(frame_height_reg) > 32'(MAX_DIMENSION))
            h_eff = DIM_W'(MAX_DIMENSION);
        else
            h_eff = DIM_W'(frame_height_reg);
    end

    assign w_last = CNT_W'(w_eff - DIM_W'(1));
    assign h_last = CNT_W'(h_eff - DIM_W'(1));

    assign idx_inc   = {1'b0, idx_reg} + {{N_W{1'b0}}, 1'b1};
    assign close     = idx_inc >= {1'b0, n_eff};
    assign last_col  = col_reg >= w_last;
    assign last_row  = row_reg >= h_last;
    assign depth_min = (sample_depth < nearest_reg) ? sample_depth : nearest_reg;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
            acc_sum[c] = sum_reg[c] + SUM_W'(sample_chan[c]);
    end

    always_comb
    begin
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        nearest_next = nearest_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        if (sample_take)
        begin
            if (close)
            begin
                idx_next     = '0;
                sum_next     = '0;
                nearest_next = '1;
                if (last_col)
                begin
                    col_next = '0;
                    row_next = last_row ? '0 : row_reg + CNT_W'(1);
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
            end
            else
            begin
                idx_next     = idx_inc[N_W-1:0];
                sum_next     = acc_sum;
                nearest_next = depth_min;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            sum_reg     <= '0;
            nearest_reg <= '1;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            nearest_reg <= nearest_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    assign pix_push  = sample_take & close;
    assign pix_sum   = acc_sum;
    assign pix_depth = depth_min;
    assign pix_n     = n_eff;
    assign pix_last  = last_col & last_row;

endmodule

`default_nettype wire

[design/msaa_queue.sv]
// Two-entry queue carrying finished pixel sums from the front end to the divider.
`default_nettype none

module msaa_queue
#(
    parameter int ENTRY_W = 90
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [ENTRY_W-1:0] push_data,
    input  wire logic               pop,
    output logic [ENTRY_W-1:0]      pop_data,
    output logic                    full,
    output logic                    empty
);

    logic [ENTRY_W-1:0] slot_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;

endmodule

`default_nettype wire

[design/msaa_back.sv]
// Back end: bit-serial rounded division of the four channel sums and the output register.
`default_nettype none

module msaa_back
    import msaa_pkg::*;
#(
    parameter int SUM_W = 12,
    parameter int N_W   = 5
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        job_valid,
    input  wire logic [CHANNELS-1:0][SUM_W-1:0] job_sum,
    input  wire depth_t                      job_depth,
    input  wire logic [N_W-1:0]              job_n,
    input  wire logic                        job_last,
    output logic                             job_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [TDATA_W-1:0]               out_data,
    output logic                             out_last
);

    localparam int REM_W = (SUM_W + 2 > N_W + CH_W + 1) ? SUM_W + 2 : N_W + CH_W + 1;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t                  state_reg, state_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic [CHANNELS-1:0][REM_W-1:0] rem_reg, rem_next;
    logic [CHANNELS-1:0]          sat_reg, sat_next;
    chan_t [CHANNELS-1:0]         quo_reg, quo_next;
    logic [REM_W-1:0]             div_reg, div_next;
    depth_t                       depth_reg, depth_next;
    logic                         last_reg, last_next;
    logic [TDATA_W-1:0]           out_data_reg;
    logic                         out_last_reg;

    logic                         out_load;
    logic [REM_W-1:0]             dbl_n;
    logic [CHANNELS-1:0][REM_W-1:0] num;
    chan_t [CHANNELS-1:0]         result;

    assign dbl_n = REM_W'(job_n) << 1;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            // 2*sum + n, divided by 2n below
            num[c]    = (REM_W'(job_sum[c]) << 1) + REM_W'(job_n);
            result[c] = sat_reg[c] ? '1 : quo_reg[c];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        sat_next   = sat_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        depth_next = depth_reg;
        last_next  = last_reg;
        job_pop    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    rem_next   = num;
                    for (int c = 0; c < CHANNELS; c++)
                        sat_next[c] = num[c] >= (dbl_n << CH_W);
                    quo_next   = '0;
                    div_next   = dbl_n << (CH_W - 1);
                    depth_next = job_depth;
                    last_next  = job_last;
                    step_next  = STEP_W'(CH_W - 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // one quotient bit per channel per cycle, msb first
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (rem_reg[c] >= div_reg)
                    begin
                        rem_next[c] = rem_reg[c] - div_reg;
                        quo_next[c] = {quo_reg[c][CH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next[c] = {quo_reg[c][CH_W-2:0], 1'b0};
                    end
                end
                div_next = div_reg >> 1;
                if (step_reg == '0)
                    state_next = ST_DONE;
                else
                    step_next = step_reg - STEP_W'(1);
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        sat_reg   <= sat_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
        depth_reg <= depth_next;
        last_reg  <= last_next;
        if (out_load)
        begin
            out_data_reg <= {depth_reg, result[3], result[2], result[1], result[0]};
            out_last_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

[design/msaa_box_resolve_unit.sv]
// Top level of the multisample box resolve block.
`default_nettype none

// Box-filter resolve of a multisampled stream. Samples (RGBA plus depth) are taken
// one per cycle in pixel order while the pixel queue is not full; after sample_count
// samples one pixel word leaves with each channel as the rounded-half-up mean and the
// least depth (unsigned compare), tlast set on the last pixel of the frame. The front
// end never stalls on its own; each pixel then passes through the back end (load, 8
// bit-serial divide steps, hand-off to the output register), which takes no new pixel
// until the last one is handed off, and the hand-off waits on m_tready. A two-word queue
// between front and back decouples the two. Config writes are always accepted
// and are meant to be made while the block is idle.
module msaa_box_resolve_unit
    import msaa_pkg::*;
#(
    parameter int MAX_SAMPLES   = 16,
    parameter int MAX_DIMENSION = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_W-1:0]     s_tdata,   // red, green, blue, alpha, depth[63:32]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_W-1:0]          m_tdata,   // red, green, blue, alpha, depth[63:32]
    output logic                        m_tlast,   // frame_end
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W   = $clog2(MAX_SAMPLES * 255 + 1);
    localparam int N_W     = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W   = $clog2(MAX_DIMENSION);
    localparam int ENTRY_W = CHANNELS * SUM_W + DEPTH_W + N_W + 1;

    logic                           sample_take;
    chan_t [CHANNELS-1:0]           sample_chan;
    logic                           q_push, q_pop, q_full, q_empty;
    logic [CHANNELS-1:0][SUM_W-1:0] pix_sum, job_sum;
    depth_t                         pix_depth, job_depth;
    logic [N_W-1:0]                 pix_n, job_n;
    logic                           pix_last, job_last;
    logic [ENTRY_W-1:0]             q_wdata, q_rdata;

    assign cfg_ready   = 1'b1;
    assign s_tready    = ~q_full;
    assign sample_take = s_tvalid & s_tready;
    assign sample_chan = s_tdata[CHANNELS*CH_W-1:0];

    msaa_front #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .MAX_DIMENSION (MAX_DIMENSION),
        .SUM_W         (SUM_W),
        .N_W           (N_W),
        .CNT_W         (CNT_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_take  (sample_take),
        .sample_chan  (sample_chan),
        .sample_depth (s_tdata[TDATA_W-1:CHANNELS*CH_W]),
        .pix_push     (q_push),
        .pix_sum      (pix_sum),
        .pix_depth    (pix_depth),
        .pix_n        (pix_n),
        .pix_last     (pix_last)
    );

    assign q_wdata = {pix_last, pix_n, pix_depth, pix_sum};

    msaa_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {job_last, job_n, job_depth, job_sum} = q_rdata;

    msaa_back #(
        .SUM_W (SUM_W),
        .N_W   (N_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (~q_empty),
        .job_sum   (job_sum),
        .job_depth (job_depth),
        .job_n     (job_n),
        .job_last  (job_last),
        .job_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // a closing sample must never find the queue full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("pixel queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pixel queue read while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |=> !q_empty)
        else $error("pushed pixel word lost");

endmodule

`default_nettype wire
